### hw/rtl/hall_click_hysteresis_calibration_top_macros.svh
// assertion macros shared by the hall click calibration block
`ifndef HALL_CLICK_HYSTERESIS_CALIBRATION_TOP_MACROS_SVH
`define HALL_CLICK_HYSTERESIS_CALIBRATION_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define HCHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hchc: same-cycle check failed");

// next-cycle implication, checked outside reset
`define HCHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hchc: next-cycle check failed");

// condition that must never hold
`define HCHC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hchc: forbidden condition seen");

`endif

### hw/rtl/hchc_pkg.sv
// shared types and constants of the hall click calibration block
package hchc_pkg;

    // threshold values after reset
    localparam int unsigned INIT_CLICK   = 2600;
    localparam int unsigned INIT_RELEASE = 2400;

    // click threshold sits at CLICK_NUM / CLICK_DEN of the idle to press span
    localparam int unsigned CLICK_NUM = 7;
    localparam int unsigned CLICK_DEN = 10;

    // calibration target code layout
    localparam int unsigned TGT_PRESS_BIT = 0;
    localparam int unsigned TGT_CH_BIT    = 1;
    localparam int unsigned TGT_BAD_BIT   = 2;

    localparam logic [2:0] ARMED_NONE = 3'd0;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_LEFT_CLICK    = 2'd0,
        REG_LEFT_RELEASE  = 2'd1,
        REG_RIGHT_CLICK   = 2'd2,
        REG_RIGHT_RELEASE = 2'd3
    } t_cfg_reg;

    // item kind carried on tuser
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_START  = 1'b1
    } t_kind;

    // per-stage transfer strobes of the pipeline
    typedef struct packed {
        logic acc;
        logic t1;
        logic t2;
        logic t3;
        logic t4;
    } t_adv;

    // item status that travels down the pipeline
    typedef struct packed {
        logic       is_sample;
        logic       done;
        logic       rej;
        logic [1:0] tgt;
        logic [2:0] armed;
        logic [3:0] gathered;
    } t_item_flags;

    // per-channel result of the detect stage
    typedef struct packed {
        logic fire;
        logic save;
        logic ready;
    } t_lane_stat;

endpackage

### hw/rtl/hchc_accum.sv
// calibration accumulator and averaging multiplier shared by both channels
module hchc_accum
    import hchc_pkg::*;
#(
    parameter int unsigned CAL_SAMPLES = 8,
    parameter int unsigned LVL_W       = 13
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_adv                    i_adv,
    input  logic                    i_kind,
    input  logic signed [LVL_W-1:0] i_hall1,
    input  logic signed [LVL_W-1:0] i_hall2,
    input  logic [2:0]              i_target,
    output t_item_flags             o_flags,
    output logic signed [LVL_W-1:0] o_hall1,
    output logic signed [LVL_W-1:0] o_hall2,
    output logic signed [LVL_W-1:0] o_avg
);

    // the magnitude of the most negative sum needs the full sum width
    localparam int unsigned CLG     = $clog2(CAL_SAMPLES);
    localparam int unsigned MAG_W   = LVL_W + CLG;
    localparam int unsigned SUM_W   = MAG_W;
    localparam int unsigned TALLY_W = $clog2(CAL_SAMPLES + 1);
    localparam int unsigned SHIFT   = MAG_W + CLG;
    localparam int unsigned RCP_W   = MAG_W + 1;
    localparam int unsigned PROD_W  = MAG_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [TALLY_W-1:0] TALLY_LAST = TALLY_W'(CAL_SAMPLES);

    // calibration state
    logic [2:0]               r_armed, n_armed;
    logic [TALLY_W-1:0]       r_tally, n_tally;
    logic signed [SUM_W-1:0]  r_sum, n_sum;

    // stage one and stage two payload
    t_item_flags              r1_flags, r2_flags, s0_flags;
    logic signed [LVL_W-1:0]  r1_hall1, r1_hall2, r2_hall1, r2_hall2;
    logic signed [SUM_W-1:0]  r1_sum;
    logic [PROD_W-1:0]        r2_prod;
    logic                     r2_neg;

    logic [1:0]               cur_tgt;
    logic signed [LVL_W-1:0]  sel_hall;
    logic signed [SUM_W-1:0]  sel_ext, s0_sum;
    logic [TALLY_W-1:0]       tally_inc;
    logic                     s0_done, s0_rej;
    logic                     s1_neg;
    logic [MAG_W-1:0]         s1_mag;
    logic [PROD_W-1:0]        s1_prod;
    logic [LVL_W-1:0]         quot;

    // running sum of the armed channel
    assign cur_tgt   = 2'(r_armed - 3'd1);
    assign sel_hall  = cur_tgt[TGT_CH_BIT] ? i_hall2 : i_hall1;
    assign sel_ext   = SUM_W'(sel_hall);
    assign s0_sum    = r_sum + sel_ext;
    assign tally_inc = r_tally + 1'b1;

    // arm, gather and finish a calibration
    always_comb begin
        n_armed = r_armed;
        n_tally = r_tally;
        n_sum   = r_sum;
        s0_done = 1'b0;
        s0_rej  = 1'b0;
        if (i_kind == KIND_START) begin
            if (!i_target[TGT_BAD_BIT]) begin
                n_armed = {1'b0, i_target[1:0]} + 3'd1;
                n_tally = '0;
                n_sum   = '0;
            end else begin
                s0_rej = 1'b1;
            end
        end else if (r_armed != ARMED_NONE) begin
            if (tally_inc == TALLY_LAST) begin
                s0_done = 1'b1;
                n_armed = ARMED_NONE;
                n_tally = '0;
                n_sum   = '0;
            end else begin
                n_tally = tally_inc;
                n_sum   = s0_sum;
            end
        end
    end

    always_comb begin
        s0_flags.is_sample = (i_kind == KIND_SAMPLE);
        s0_flags.done      = s0_done;
        s0_flags.rej       = s0_rej;
        s0_flags.tgt       = cur_tgt;
        s0_flags.armed     = n_armed;
        s0_flags.gathered  = 4'(n_tally);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= ARMED_NONE;
            r_tally <= '0;
            r_sum   <= '0;
        end else if (i_adv.acc) begin
            r_armed <= n_armed;
            r_tally <= n_tally;
            r_sum   <= n_sum;
        end
    end

    // stage one register: finished sum and item status
    always_ff @(posedge i_clk) begin
        if (i_adv.acc) begin
            r1_flags <= s0_flags;
            r1_hall1 <= i_hall1;
            r1_hall2 <= i_hall2;
            r1_sum   <= s0_sum;
        end
    end

    // magnitude times reciprocal of the sample count
    assign s1_neg  = r1_sum[SUM_W-1];
    assign s1_mag  = MAG_W'(s1_neg ? -r1_sum : r1_sum);
    assign s1_prod = PROD_W'(s1_mag) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_adv.t1) begin
            r2_flags <= r1_flags;
            r2_hall1 <= r1_hall1;
            r2_hall2 <= r1_hall2;
            r2_prod  <= s1_prod;
            r2_neg   <= s1_neg;
        end
    end

    // average, truncated toward zero
    assign quot    = r2_prod[SHIFT +: LVL_W];
    assign o_avg   = r2_neg ? -$signed(quot) : $signed(quot);
    assign o_flags = r2_flags;
    assign o_hall1 = r2_hall1;
    assign o_hall2 = r2_hall2;

endmodule

### hw/rtl/hchc_lane.sv
// one channel lane: level store, threshold math and hysteresis detector
module hchc_lane
    import hchc_pkg::*;
#(
    parameter int unsigned LVL_W = 13
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_adv                    i_adv,
    input  logic                    i_cfg_we_click,
    input  logic                    i_cfg_we_rel,
    input  logic signed [LVL_W-1:0] i_cfg_data,
    input  logic                    i_is_sample,
    input  logic                    i_upd,
    input  logic                    i_press,
    input  logic signed [LVL_W-1:0] i_avg,
    input  logic signed [LVL_W-1:0] i_hall,
    output t_lane_stat              o_stat,
    output logic signed [LVL_W-1:0] o_click_thr,
    output logic signed [LVL_W-1:0] o_rel_thr
);

    localparam int unsigned P7_W     = LVL_W + $clog2(CLICK_NUM + 1);
    localparam int unsigned SHIFT10  = P7_W + $clog2(CLICK_DEN);
    localparam int unsigned RCP10_W  = P7_W + 1;
    localparam int unsigned PROD10_W = P7_W + RCP10_W;
    localparam logic [RCP10_W-1:0] RECIP10 =
        RCP10_W'(((64'd1 << SHIFT10) + 64'(CLICK_DEN) - 64'd1) / 64'(CLICK_DEN));

    // stored levels and thresholds
    logic signed [LVL_W-1:0] r_idle, r_press, r_click, r_rel;
    logic                    r_cap_idle, r_cap_press, r_lat, r_ready;

    // stage three and four payload
    logic                    r3_ok, r3_is_sample, r4_ok, r4_is_sample;
    logic [LVL_W-1:0]        r3_delta;
    logic signed [LVL_W-1:0] r3_idle, r3_hall, r4_idle, r4_hall, r4_rel;
    logic [PROD10_W-1:0]     r4_prod;

    logic signed [LVL_W-1:0] idle_n, press_n;
    logic                    cap_idle_n, cap_press_n, s2_ok;
    logic signed [LVL_W:0]   s2_diff;
    logic [P7_W-1:0]         s3_p7;
    logic [PROD10_W-1:0]     s3_prod;
    logic [LVL_W-1:0]        s3_rel;
    logic [LVL_W-1:0]        s4_click_u;
    logic signed [LVL_W-1:0] click_use, rel_use;
    logic                    fire, n_lat;

    // new level merged with the stored pair
    assign idle_n      = (i_upd && !i_press) ? i_avg : r_idle;
    assign press_n     = (i_upd && i_press) ? i_avg : r_press;
    assign cap_idle_n  = r_cap_idle | (i_upd & ~i_press);
    assign cap_press_n = r_cap_press | (i_upd & i_press);
    assign s2_ok       = i_upd && cap_idle_n && cap_press_n && (press_n > idle_n);
    assign s2_diff     = (LVL_W+1)'(press_n) - (LVL_W+1)'(idle_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_idle  <= 1'b0;
            r_cap_press <= 1'b0;
        end else if (i_adv.t2) begin
            r_cap_idle  <= cap_idle_n;
            r_cap_press <= cap_press_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.t2) begin
            r_idle       <= idle_n;
            r_press      <= press_n;
            r3_ok        <= s2_ok;
            r3_delta     <= s2_diff[LVL_W-1:0];
            r3_idle      <= idle_n;
            r3_hall      <= i_hall;
            r3_is_sample <= i_is_sample;
        end
    end

    // seven tenths of the span through a reciprocal, half span by shift
    assign s3_p7   = (P7_W'(r3_delta) << 3) - P7_W'(r3_delta);
    assign s3_prod = PROD10_W'(s3_p7) * PROD10_W'(RECIP10);
    assign s3_rel  = LVL_W'(r3_idle) + (r3_delta >> 1);

    always_ff @(posedge i_clk) begin
        if (i_adv.t3) begin
            r4_ok        <= r3_ok;
            r4_idle      <= r3_idle;
            r4_hall      <= r3_hall;
            r4_is_sample <= r3_is_sample;
            r4_prod      <= s3_prod;
            r4_rel       <= $signed(s3_rel);
        end
    end

    // thresholds in force for this item
    assign s4_click_u = LVL_W'(r4_idle) + r4_prod[SHIFT10 +: LVL_W];
    assign click_use  = r4_ok ? $signed(s4_click_u) : r_click;
    assign rel_use    = r4_ok ? r4_rel : r_rel;

    // latched hysteresis detector
    assign fire = r4_is_sample && !r_lat && (r4_hall >= click_use);

    always_comb begin
        n_lat = r_lat;
        if (r4_is_sample) begin
            if (fire) begin
                n_lat = 1'b1;
            end else if (r_lat && (r4_hall < rel_use)) begin
                n_lat = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat   <= 1'b0;
            r_ready <= 1'b0;
        end else if (i_adv.t4) begin
            r_lat   <= n_lat;
            r_ready <= r_ready | r4_ok;
        end
    end

    // working thresholds: register writes or calibration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click <= LVL_W'(INIT_CLICK);
            r_rel   <= LVL_W'(INIT_RELEASE);
        end else begin
            if (i_cfg_we_click) begin
                r_click <= i_cfg_data;
            end else if (i_adv.t4) begin
                r_click <= click_use;
            end
            if (i_cfg_we_rel) begin
                r_rel <= i_cfg_data;
            end else if (i_adv.t4) begin
                r_rel <= rel_use;
            end
        end
    end

    always_comb begin
        o_stat.fire  = fire;
        o_stat.save  = r4_ok;
        o_stat.ready = r_ready | r4_ok;
    end

    assign o_click_thr = click_use;
    assign o_rel_thr   = rel_use;

endmodule

### hw/rtl/hall_click_hysteresis_calibration_top.sv
// top level of the two-channel hall click detector with two-point calibration
// Usage:
// - input stream: tuser is the kind (0 sample pair, 1 start calibration),
//   tdata carries both channel samples and the calibration target
// - output stream: one result per input transfer, in input order
// - config port: a write to one of the four threshold registers loads the
//   working threshold at once; write only while no item is in flight
// - a start arms one target; after CAL_SAMPLES sample pairs the average of
//   that channel becomes its idle or press level and, once both levels are
//   usable, the click and release thresholds are recomputed (save pulse)
// - path: a taken item passes through five register stages (sum, average
//   multiply, level store, span multiply, detect/output) to its result
// - throughput: one item per cycle unless the receiver stalls, set by the
//   pipeline; the threshold and latch state lives in the detect stage so
//   items never wait on each other
// - receiver stall: the output register holds; empty stages keep filling
//   and tready drops only when every stage is full
// - reset: thresholds go to 2600 / 2400, level capture flags, ready flags,
//   latches and the armed target clear, and the pipeline empties
`include "hall_click_hysteresis_calibration_top_macros.svh"

module hall_click_hysteresis_calibration_top
    import hchc_pkg::*;
#(
    parameter int unsigned CAL_SAMPLES = 8,
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    // hall1_sample, hall2_sample, calib_target
    input  logic [((2*(SAMPLE_BITS+1)+3+7)/8)*8-1:0]    i_s_tdata,
    // kind
    input  logic                                        i_s_tuser,
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // left_click, right_click, left_ready, right_ready, armed_target,
    // gathered_count, save_request, left_click_level, left_release_level,
    // right_click_level, right_release_level, start_rejected
    output logic [((4*(SAMPLE_BITS+1)+13+7)/8)*8-1:0]   o_m_tdata,
    input  logic                                        i_cfg_we,
    input  logic [1:0]                                  i_cfg_idx,
    input  logic [SAMPLE_BITS:0]                        i_cfg_data
);

    localparam int unsigned LVL_W      = SAMPLE_BITS + 1;
    localparam int unsigned OUT_W      = 4 * LVL_W + 13;
    localparam int unsigned OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int unsigned OB_LREADY  = 2;
    localparam int unsigned OB_RREADY  = 3;
    localparam int unsigned OB_SAVE    = 11;

    // stage valid bits and output register
    logic                  r_v1, r_v2, r_v3, r_v4, r_vo;
    logic [OUT_DATA_W-1:0] r_out, n_out;
    t_item_flags           r3_flags, r4_flags, acc_flags;

    logic free_o, free4, free3, free2, free1;
    t_adv adv;

    logic signed [LVL_W-1:0] in_hall1, in_hall2, acc_hall1, acc_hall2, acc_avg;
    logic signed [LVL_W-1:0] cfg_data;
    logic signed [LVL_W-1:0] l_click, l_rel, r_click_thr, r_rel_thr;
    logic [2:0]              in_target;
    t_lane_stat              l_stat, r_stat;
    logic                    we_lc, we_lr, we_rc, we_rr;
    logic                    upd_left, upd_right;

    // input unpacking
    assign in_hall1  = $signed(i_s_tdata[LVL_W-1:0]);
    assign in_hall2  = $signed(i_s_tdata[2*LVL_W-1:LVL_W]);
    assign in_target = i_s_tdata[2*LVL_W+2:2*LVL_W];
    assign cfg_data  = $signed(i_cfg_data);

    // ready chain: a stage takes when empty or when its content moves on
    assign free_o = !r_vo || i_m_tready;
    assign free4  = !r_v4 || free_o;
    assign free3  = !r_v3 || free4;
    assign free2  = !r_v2 || free3;
    assign free1  = !r_v1 || free2;

    always_comb begin
        adv.acc = i_s_tvalid && free1;
        adv.t1  = r_v1 && free2;
        adv.t2  = r_v2 && free3;
        adv.t3  = r_v3 && free4;
        adv.t4  = r_v4 && free_o;
    end

    assign o_s_tready = free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= adv.acc || (r_v1 && !adv.t1);
            r_v2 <= adv.t1 || (r_v2 && !adv.t2);
            r_v3 <= adv.t2 || (r_v3 && !adv.t3);
            r_v4 <= adv.t3 || (r_v4 && !adv.t4);
            r_vo <= adv.t4 || (r_vo && !i_m_tready);
        end
    end

    // config register decode
    assign we_lc = i_cfg_we && (i_cfg_idx == REG_LEFT_CLICK);
    assign we_lr = i_cfg_we && (i_cfg_idx == REG_LEFT_RELEASE);
    assign we_rc = i_cfg_we && (i_cfg_idx == REG_RIGHT_CLICK);
    assign we_rr = i_cfg_we && (i_cfg_idx == REG_RIGHT_RELEASE);

    hchc_accum #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .LVL_W       (LVL_W)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_kind   (i_s_tuser),
        .i_hall1  (in_hall1),
        .i_hall2  (in_hall2),
        .i_target (in_target),
        .o_flags  (acc_flags),
        .o_hall1  (acc_hall1),
        .o_hall2  (acc_hall2),
        .o_avg    (acc_avg)
    );

    // route the finished average to its channel
    assign upd_left  = acc_flags.done && !acc_flags.tgt[TGT_CH_BIT];
    assign upd_right = acc_flags.done && acc_flags.tgt[TGT_CH_BIT];

    hchc_lane #(
        .LVL_W (LVL_W)
    ) u_lane_left (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_cfg_we_click (we_lc),
        .i_cfg_we_rel   (we_lr),
        .i_cfg_data     (cfg_data),
        .i_is_sample    (acc_flags.is_sample),
        .i_upd          (upd_left),
        .i_press        (acc_flags.tgt[TGT_PRESS_BIT]),
        .i_avg          (acc_avg),
        .i_hall         (acc_hall1),
        .o_stat         (l_stat),
        .o_click_thr    (l_click),
        .o_rel_thr      (l_rel)
    );

    hchc_lane #(
        .LVL_W (LVL_W)
    ) u_lane_right (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_cfg_we_click (we_rc),
        .i_cfg_we_rel   (we_rr),
        .i_cfg_data     (cfg_data),
        .i_is_sample    (acc_flags.is_sample),
        .i_upd          (upd_right),
        .i_press        (acc_flags.tgt[TGT_PRESS_BIT]),
        .i_avg          (acc_avg),
        .i_hall         (acc_hall2),
        .o_stat         (r_stat),
        .o_click_thr    (r_click_thr),
        .o_rel_thr      (r_rel_thr)
    );

    // item status follows the lanes through stages three and four
    always_ff @(posedge i_clk) begin
        if (adv.t2) begin
            r3_flags <= acc_flags;
        end
        if (adv.t3) begin
            r4_flags <= r3_flags;
        end
    end

    // merge both lanes into one result, first field in the low bits
    assign n_out = OUT_DATA_W'({r4_flags.rej,
                                r_rel_thr, r_click_thr, l_rel, l_click,
                                l_stat.save | r_stat.save,
                                r4_flags.gathered, r4_flags.armed,
                                r_stat.ready, l_stat.ready,
                                r_stat.fire, l_stat.fire});

    always_ff @(posedge i_clk) begin
        if (adv.t4) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = r_out;

    // a save pulse always comes with a ready channel
    `HCHC_ASSERT_IMPLY(a_save_has_ready, i_clk, i_rst_n, o_m_tvalid && r_out[OB_SAVE], r_out[OB_LREADY] || r_out[OB_RREADY])
    // only one channel can finish a calibration per item
    `HCHC_ASSERT_NEVER(a_single_save, i_clk, i_rst_n, adv.t4 && l_stat.save && r_stat.save)
    // a finished calibration leaves nothing armed
    `HCHC_ASSERT_IMPLY(a_done_disarms, i_clk, i_rst_n, r_v2 && acc_flags.done, (acc_flags.armed == ARMED_NONE) && (acc_flags.gathered == 4'd0))
    // an input transfer always lands in stage one
    `HCHC_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_v1)

endmodule
